// File: rtl/core/hsvc_pkg.sv
// shared constants and types for the hsv to rgb converter
package hsvc_pkg;

    // default fraction widths of hue and of saturation / value
    localparam int HUE_FRAC_BITS_DEF = 6;
    localparam int SV_FRAC_BITS_DEF  = 8;

    // integer bits needed to hold 360 degrees
    localparam int HUE_INT_BITS = 9;

    // color component width
    localparam int COLOR_W = 8;

    // scaled component before the final divide by 15, at most 255 * 15
    localparam int          Y_W   = 12;
    localparam logic [11:0] Y_MAX = 12'd3825;

    // floor(y / 15) = (y * RECIP15) >> RECIP15_SHIFT for every y below 4096
    localparam logic [15:0] RECIP15       = 16'd34953;
    localparam int          RECIP15_SHIFT = 19;

    // 60-degree hue sector
    typedef enum logic [2:0] {
        SEC_0 = 3'd0,
        SEC_1 = 3'd1,
        SEC_2 = 3'd2,
        SEC_3 = 3'd3,
        SEC_4 = 3'd4,
        SEC_5 = 3'd5
    } sector_t;

    // which term a color channel carries: chroma, secondary or zero
    typedef enum logic [1:0] {
        SEL_C = 2'd0,
        SEL_X = 2'd1,
        SEL_Z = 2'd2
    } chan_sel_t;

endpackage

// File: rtl/core/hsvc_hsv_if.sv
// hsv pixel channel with valid / ready handshake
interface hsvc_hsv_if #(
    parameter int HUE_W = hsvc_pkg::HUE_FRAC_BITS_DEF + hsvc_pkg::HUE_INT_BITS,
    parameter int SV_W  = hsvc_pkg::SV_FRAC_BITS_DEF + 1
);
    logic              valid;
    logic              ready;
    logic [HUE_W-1:0]  hue;
    logic [SV_W-1:0]   saturation;
    logic [SV_W-1:0]   brightness;

    modport source (output valid, output hue, output saturation, output brightness,
                    input ready);
    modport sink   (input valid, input hue, input saturation, input brightness,
                    output ready);
endinterface

// File: rtl/core/hsvc_rgb_if.sv
// rgb pixel channel with valid / ready handshake
interface hsvc_rgb_if;
    import hsvc_pkg::*;

    logic               valid;
    logic               ready;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

// File: rtl/core/hsvc_sector.sv
// input clamp, hue sector decode, hue fraction and channel routing (two stages)
module hsvc_sector #(
    parameter int HUE_FRAC_BITS = hsvc_pkg::HUE_FRAC_BITS_DEF,
    parameter int SV_FRAC_BITS  = hsvc_pkg::SV_FRAC_BITS_DEF
) (
    input  logic                                            clk,
    input  logic                                            rst_n,
    input  logic                                            in_valid,
    output logic                                            in_ready,
    input  logic [HUE_FRAC_BITS+hsvc_pkg::HUE_INT_BITS-1:0] hue,
    input  logic [SV_FRAC_BITS:0]                           saturation,
    input  logic [SV_FRAC_BITS:0]                           brightness,
    output logic                                            out_valid,
    input  logic                                            out_ready,
    output logic [HUE_FRAC_BITS+5:0]                        frac,
    output logic [SV_FRAC_BITS+HUE_FRAC_BITS+5:0]           zero_term,
    output logic [SV_FRAC_BITS:0]                           sat,
    output logic [SV_FRAC_BITS:0]                           bri,
    output hsvc_pkg::chan_sel_t                             sel_red,
    output hsvc_pkg::chan_sel_t                             sel_green,
    output hsvc_pkg::chan_sel_t                             sel_blue
);
    import hsvc_pkg::*;

    localparam int HW  = HUE_FRAC_BITS + HUE_INT_BITS;
    localparam int FW  = HUE_FRAC_BITS + 6;
    localparam int SW  = SV_FRAC_BITS + 1;
    localparam int TW  = SV_FRAC_BITS + HUE_FRAC_BITS + 6;
    localparam int DEG = 60 * (2 ** HUE_FRAC_BITS);

    localparam logic [HW-1:0] B1    = HW'(DEG);
    localparam logic [HW-1:0] B2    = HW'(2 * DEG);
    localparam logic [HW-1:0] B3    = HW'(3 * DEG);
    localparam logic [HW-1:0] B4    = HW'(4 * DEG);
    localparam logic [HW-1:0] B5    = HW'(5 * DEG);
    localparam logic [HW-1:0] B6    = HW'(6 * DEG);
    localparam logic [SW-1:0] ONE   = SW'(2 ** SV_FRAC_BITS);
    localparam logic [TW-1:0] DEG_T = TW'(DEG);
    localparam logic [FW-1:0] DEG_F = FW'(DEG);

    // stage a registers
    logic            a_vld_reg;
    logic [HW-1:0]   a_hue_reg;
    sector_t         a_sec_reg;
    logic [SW-1:0]   a_sat_reg;
    logic [SW-1:0]   a_bri_reg;

    // stage b registers
    logic            b_vld_reg;
    logic [FW-1:0]   b_frac_reg;
    logic [TW-1:0]   b_zt_reg;
    logic [SW-1:0]   b_sat_reg;
    logic [SW-1:0]   b_bri_reg;
    chan_sel_t       b_sel_r_reg;
    chan_sel_t       b_sel_g_reg;
    chan_sel_t       b_sel_b_reg;

    logic            a_ld;
    logic            b_ld;
    logic            out_of_range;
    logic [HW-1:0]   a_hue_next;
    sector_t         a_sec_next;
    logic [SW-1:0]   a_sat_next;
    logic [SW-1:0]   a_bri_next;
    logic [HW-1:0]   hue_diff;
    logic [FW-1:0]   b_frac_next;
    logic [TW-1:0]   b_zt_next;
    chan_sel_t       b_sel_r_next;
    chan_sel_t       b_sel_g_next;
    chan_sel_t       b_sel_b_next;

    // stage advance: a stage loads when empty or when its word moves on
    assign b_ld     = !b_vld_reg || out_ready;
    assign a_ld     = !a_vld_reg || b_ld;
    assign in_ready = a_ld;

    // clamp inputs and decode the sector; a hue of a full turn or more goes to zero
    always_comb
    begin
        out_of_range = (hue >= B6);
        a_hue_next   = out_of_range ? '0 : hue;
        a_sat_next   = (saturation > ONE) ? ONE : saturation;
        a_bri_next   = (brightness > ONE) ? ONE : brightness;
        priority if (out_of_range)
            a_sec_next = SEC_0;
        else if (hue >= B5)
            a_sec_next = SEC_5;
        else if (hue >= B4)
            a_sec_next = SEC_4;
        else if (hue >= B3)
            a_sec_next = SEC_3;
        else if (hue >= B2)
            a_sec_next = SEC_2;
        else if (hue >= B1)
            a_sec_next = SEC_1;
        else
            a_sec_next = SEC_0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_vld_reg <= 1'b0;
        else if (a_ld)
            a_vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (a_ld && in_valid)
        begin
            a_hue_reg <= a_hue_next;
            a_sec_reg <= a_sec_next;
            a_sat_reg <= a_sat_next;
            a_bri_reg <= a_bri_next;
        end
    end

    // hue fraction rising in even sectors, falling in odd ones, plus routing
    always_comb
    begin
        unique case (a_sec_reg)
            SEC_0:
            begin
                hue_diff     = a_hue_reg;
                b_sel_r_next = SEL_C;
                b_sel_g_next = SEL_X;
                b_sel_b_next = SEL_Z;
            end
            SEC_1:
            begin
                hue_diff     = B2 - a_hue_reg;
                b_sel_r_next = SEL_X;
                b_sel_g_next = SEL_C;
                b_sel_b_next = SEL_Z;
            end
            SEC_2:
            begin
                hue_diff     = a_hue_reg - B2;
                b_sel_r_next = SEL_Z;
                b_sel_g_next = SEL_C;
                b_sel_b_next = SEL_X;
            end
            SEC_3:
            begin
                hue_diff     = B4 - a_hue_reg;
                b_sel_r_next = SEL_Z;
                b_sel_g_next = SEL_X;
                b_sel_b_next = SEL_C;
            end
            SEC_4:
            begin
                hue_diff     = a_hue_reg - B4;
                b_sel_r_next = SEL_X;
                b_sel_g_next = SEL_Z;
                b_sel_b_next = SEL_C;
            end
            SEC_5:
            begin
                hue_diff     = B6 - a_hue_reg;
                b_sel_r_next = SEL_C;
                b_sel_g_next = SEL_Z;
                b_sel_b_next = SEL_X;
            end
            default:
            begin
                hue_diff     = '0;
                b_sel_r_next = SEL_Z;
                b_sel_g_next = SEL_Z;
                b_sel_b_next = SEL_Z;
            end
        endcase
        b_frac_next = hue_diff[FW-1:0];
        // offset term at full scale: (1 - s) * deg
        b_zt_next   = TW'(ONE - a_sat_reg) * DEG_T;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_vld_reg <= 1'b0;
        else if (b_ld)
            b_vld_reg <= a_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (b_ld && a_vld_reg)
        begin
            b_frac_reg  <= b_frac_next;
            b_zt_reg    <= b_zt_next;
            b_sat_reg   <= a_sat_reg;
            b_bri_reg   <= a_bri_reg;
            b_sel_r_reg <= b_sel_r_next;
            b_sel_g_reg <= b_sel_g_next;
            b_sel_b_reg <= b_sel_b_next;
        end
    end

    // outputs
    assign out_valid = b_vld_reg;
    assign frac      = b_frac_reg;
    assign zero_term = b_zt_reg;
    assign sat       = b_sat_reg;
    assign bri       = b_bri_reg;
    assign sel_red   = b_sel_r_reg;
    assign sel_green = b_sel_g_reg;
    assign sel_blue  = b_sel_b_reg;

    // full-turn hue lands in the first sector at zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && hue >= B6) |=> (a_hue_reg == '0 && a_sec_reg == SEC_0))
        else $error("hsvc_sector: hue wrap failed");

    // clamped saturation and value never exceed one
    assert property (@(posedge clk) disable iff (!rst_n)
        a_vld_reg |-> (a_sat_reg <= ONE && a_bri_reg <= ONE))
        else $error("hsvc_sector: clamp failed");

    // hue fraction stays within one sector width
    assert property (@(posedge clk) disable iff (!rst_n)
        b_vld_reg |-> (b_frac_reg <= DEG_F))
        else $error("hsvc_sector: hue fraction out of range");

    // each term goes to exactly one channel
    assert property (@(posedge clk) disable iff (!rst_n)
        b_vld_reg |->
            ($countones({b_sel_r_reg == SEL_C, b_sel_g_reg == SEL_C, b_sel_b_reg == SEL_C}) == 1
          && $countones({b_sel_r_reg == SEL_X, b_sel_g_reg == SEL_X, b_sel_b_reg == SEL_X}) == 1))
        else $error("hsvc_sector: channel routing not a permutation");

endmodule

// File: rtl/core/hsvc_scale.sv
// per-channel term build, value multiply and 255 scaling (four stages)
module hsvc_scale #(
    parameter int HUE_FRAC_BITS = hsvc_pkg::HUE_FRAC_BITS_DEF,
    parameter int SV_FRAC_BITS  = hsvc_pkg::SV_FRAC_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [HUE_FRAC_BITS+5:0]              frac,
    input  logic [SV_FRAC_BITS+HUE_FRAC_BITS+5:0] zero_term,
    input  logic [SV_FRAC_BITS:0]                 sat,
    input  logic [SV_FRAC_BITS:0]                 bri,
    input  hsvc_pkg::chan_sel_t                   sel_red,
    input  hsvc_pkg::chan_sel_t                   sel_green,
    input  hsvc_pkg::chan_sel_t                   sel_blue,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [hsvc_pkg::Y_W-1:0]              y_red,
    output logic [hsvc_pkg::Y_W-1:0]              y_green,
    output logic [hsvc_pkg::Y_W-1:0]              y_blue
);
    import hsvc_pkg::*;

    localparam int SW    = SV_FRAC_BITS + 1;
    localparam int TW    = SV_FRAC_BITS + HUE_FRAC_BITS + 6;
    localparam int PW    = SW + TW;
    localparam int SHIFT = 2 * SV_FRAC_BITS + HUE_FRAC_BITS + 2;
    localparam int DEG   = 60 * (2 ** HUE_FRAC_BITS);

    // chroma term at full scale: one * deg
    localparam logic [TW-1:0] FULL_T = TW'(DEG) << SV_FRAC_BITS;

    // stage c: s * fraction
    logic                 c_vld_reg;
    logic [TW-1:0]        c_sf_reg;
    logic [TW-1:0]        c_zt_reg;
    logic [SW-1:0]        c_bri_reg;
    chan_sel_t            c_sel_reg [3];

    // stage d: channel terms
    logic                 d_vld_reg;
    logic [TW-1:0]        d_t_reg [3];
    logic [SW-1:0]        d_bri_reg;

    // stage e: value times term
    logic                 e_vld_reg;
    logic [PW-1:0]        e_p_reg [3];

    // stage f: times 255 and shifted down
    logic                 f_vld_reg;
    logic [Y_W-1:0]       f_y_reg [3];

    logic                 c_ld;
    logic                 d_ld;
    logic                 e_ld;
    logic                 f_ld;
    logic [TW-1:0]        c_sf_next;
    logic [TW-1:0]        tx;
    logic [TW-1:0]        d_t_next [3];
    logic [PW-1:0]        e_p_next [3];
    logic [PW+7:0]        prod255 [3];
    logic [Y_W-1:0]       f_y_next [3];

    // stage advance chain
    assign f_ld     = !f_vld_reg || out_ready;
    assign e_ld     = !e_vld_reg || f_ld;
    assign d_ld     = !d_vld_reg || e_ld;
    assign c_ld     = !c_vld_reg || d_ld;
    assign in_ready = c_ld;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_vld_reg <= 1'b0;
            d_vld_reg <= 1'b0;
            e_vld_reg <= 1'b0;
            f_vld_reg <= 1'b0;
        end
        else
        begin
            if (c_ld)
                c_vld_reg <= in_valid;
            if (d_ld)
                d_vld_reg <= c_vld_reg;
            if (e_ld)
                e_vld_reg <= d_vld_reg;
            if (f_ld)
                f_vld_reg <= e_vld_reg;
        end
    end

    // secondary slope: s * fraction never exceeds one * deg
    assign c_sf_next = TW'(TW'(sat) * TW'(frac));

    always_ff @(posedge clk)
    begin
        if (c_ld && in_valid)
        begin
            c_sf_reg     <= c_sf_next;
            c_zt_reg     <= zero_term;
            c_bri_reg    <= bri;
            c_sel_reg[0] <= sel_red;
            c_sel_reg[1] <= sel_green;
            c_sel_reg[2] <= sel_blue;
        end
    end

    // channel term: full for chroma, slope plus offset for secondary, offset alone
    assign tx = c_sf_reg + c_zt_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            unique case (c_sel_reg[i])
                SEL_C:   d_t_next[i] = FULL_T;
                SEL_X:   d_t_next[i] = tx;
                SEL_Z:   d_t_next[i] = c_zt_reg;
                default: d_t_next[i] = '0;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (d_ld && c_vld_reg)
        begin
            d_t_reg   <= d_t_next;
            d_bri_reg <= c_bri_reg;
        end
    end

    // value multiply, one per channel
    always_comb
    begin
        for (int i = 0; i < 3; i++)
            e_p_next[i] = PW'(d_bri_reg) * PW'(d_t_reg[i]);
    end

    always_ff @(posedge clk)
    begin
        if (e_ld && d_vld_reg)
            e_p_reg <= e_p_next;
    end

    // times 255 by shift and subtract, then drop the power-of-two part of the divisor
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            prod255[i]  = {e_p_reg[i], 8'b0} - {8'b0, e_p_reg[i]};
            f_y_next[i] = prod255[i][SHIFT+Y_W-1:SHIFT];
        end
    end

    always_ff @(posedge clk)
    begin
        if (f_ld && e_vld_reg)
            f_y_reg <= f_y_next;
    end

    assign out_valid = f_vld_reg;
    assign y_red     = f_y_reg[0];
    assign y_green   = f_y_reg[1];
    assign y_blue    = f_y_reg[2];

    // channel terms never exceed the full-scale term
    assert property (@(posedge clk) disable iff (!rst_n)
        d_vld_reg |-> (d_t_reg[0] <= FULL_T && d_t_reg[1] <= FULL_T && d_t_reg[2] <= FULL_T))
        else $error("hsvc_scale: channel term above full scale");

    // scaled value stays within 255 * 15 so the divide yields eight bits
    assert property (@(posedge clk) disable iff (!rst_n)
        f_vld_reg |-> (f_y_reg[0] <= Y_MAX && f_y_reg[1] <= Y_MAX && f_y_reg[2] <= Y_MAX))
        else $error("hsvc_scale: scaled value out of range");

endmodule

// File: rtl/core/hsvc_div15.sv
// divide by 15 through a reciprocal multiply, into the output register
module hsvc_div15 (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [hsvc_pkg::Y_W-1:0]     y_red,
    input  logic [hsvc_pkg::Y_W-1:0]     y_green,
    input  logic [hsvc_pkg::Y_W-1:0]     y_blue,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [hsvc_pkg::COLOR_W-1:0] red,
    output logic [hsvc_pkg::COLOR_W-1:0] green,
    output logic [hsvc_pkg::COLOR_W-1:0] blue
);
    import hsvc_pkg::*;

    localparam int MW = Y_W + 16;

    logic               g_vld_reg;
    logic [COLOR_W-1:0] g_q_reg [3];
    logic               g_ld;
    logic [Y_W-1:0]     y_in [3];
    logic [MW-1:0]      mul [3];
    logic [COLOR_W-1:0] g_q_next [3];

    assign g_ld     = !g_vld_reg || out_ready;
    assign in_ready = g_ld;

    assign y_in[0] = y_red;
    assign y_in[1] = y_green;
    assign y_in[2] = y_blue;

    // floor(y / 15) for y below 3840, where the quotient fits eight bits
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mul[i]      = MW'(y_in[i]) * MW'(RECIP15);
            g_q_next[i] = mul[i][RECIP15_SHIFT+COLOR_W-1:RECIP15_SHIFT];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            g_vld_reg <= 1'b0;
        else if (g_ld)
            g_vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (g_ld && in_valid)
            g_q_reg <= g_q_next;
    end

    assign out_valid = g_vld_reg;
    assign red       = g_q_reg[0];
    assign green     = g_q_reg[1];
    assign blue      = g_q_reg[2];

endmodule

// File: rtl/core/hsv_to_rgb_converter_core.sv
// hsv to rgb pixel converter top level
// each accepted hsv word passes stages a, b (sector), c, d, e, f (scale) and g (divide) in order
// throughput: one pixel per cycle while the output is ready; every stage has its own valid bit and
// loads whenever it is empty or its word moves on, so bubbles close up
// the last stage is the output register; a stall holds every occupied stage
// reset (rst_n low, asynchronous) clears all valid bits, data registers are not reset
module hsv_to_rgb_converter_core #(
    parameter int HUE_FRAC_BITS = hsvc_pkg::HUE_FRAC_BITS_DEF,
    parameter int SV_FRAC_BITS  = hsvc_pkg::SV_FRAC_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    hsvc_hsv_if.sink         hsv,
    hsvc_rgb_if.source       rgb
);
    import hsvc_pkg::*;

    localparam int FW = HUE_FRAC_BITS + 6;
    localparam int SW = SV_FRAC_BITS + 1;
    localparam int TW = SV_FRAC_BITS + HUE_FRAC_BITS + 6;

    // sector stage to scale stage
    logic             sec_valid;
    logic             sec_ready;
    logic [FW-1:0]    sec_frac;
    logic [TW-1:0]    sec_zt;
    logic [SW-1:0]    sec_sat;
    logic [SW-1:0]    sec_bri;
    chan_sel_t        sec_sel_r;
    chan_sel_t        sec_sel_g;
    chan_sel_t        sec_sel_b;

    // scale stage to divider
    logic             scl_valid;
    logic             scl_ready;
    logic [Y_W-1:0]   scl_y_r;
    logic [Y_W-1:0]   scl_y_g;
    logic [Y_W-1:0]   scl_y_b;

    // clamp, sector decode and routing
    hsvc_sector #(
        .HUE_FRAC_BITS (HUE_FRAC_BITS),
        .SV_FRAC_BITS  (SV_FRAC_BITS)
    ) u_sector (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (hsv.valid),
        .in_ready   (hsv.ready),
        .hue        (hsv.hue),
        .saturation (hsv.saturation),
        .brightness (hsv.brightness),
        .out_valid  (sec_valid),
        .out_ready  (sec_ready),
        .frac       (sec_frac),
        .zero_term  (sec_zt),
        .sat        (sec_sat),
        .bri        (sec_bri),
        .sel_red    (sec_sel_r),
        .sel_green  (sec_sel_g),
        .sel_blue   (sec_sel_b)
    );

    // channel terms and scaling
    hsvc_scale #(
        .HUE_FRAC_BITS (HUE_FRAC_BITS),
        .SV_FRAC_BITS  (SV_FRAC_BITS)
    ) u_scale (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (sec_valid),
        .in_ready   (sec_ready),
        .frac       (sec_frac),
        .zero_term  (sec_zt),
        .sat        (sec_sat),
        .bri        (sec_bri),
        .sel_red    (sec_sel_r),
        .sel_green  (sec_sel_g),
        .sel_blue   (sec_sel_b),
        .out_valid  (scl_valid),
        .out_ready  (scl_ready),
        .y_red      (scl_y_r),
        .y_green    (scl_y_g),
        .y_blue     (scl_y_b)
    );

    // final divide and output register
    hsvc_div15 u_div15 (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (scl_valid),
        .in_ready   (scl_ready),
        .y_red      (scl_y_r),
        .y_green    (scl_y_g),
        .y_blue     (scl_y_b),
        .out_valid  (rgb.valid),
        .out_ready  (rgb.ready),
        .red        (rgb.red),
        .green      (rgb.green),
        .blue       (rgb.blue)
    );

endmodule

// File: test/tb_hsv_to_rgb_converter_core.sv
// testbench for the hsv to rgb converter core: bursty pixel stream, stalled sink, scoreboard
`timescale 1ns / 100ps

module tb_hsv_to_rgb_converter_core;
    import hsvc_pkg::*;

    localparam int          HALF_PERIOD = 2;
    localparam int          RESET_CYCLES = 6;
    localparam int          PIPE_LATENCY = 7;
    localparam int          RANDOM_PIXELS = 600;
    localparam int          CYCLE_LIMIT = 200000;
    localparam int unsigned DEG_UNITS = 60 << HUE_FRAC_BITS_DEF;
    localparam int unsigned HUE_FULL = 360 << HUE_FRAC_BITS_DEF;
    localparam int unsigned SV_ONE = 1 << SV_FRAC_BITS_DEF;

    typedef struct packed {
        logic [14:0] hue;
        logic [8:0]  saturation;
        logic [8:0]  brightness;
    } hsv_word_t;

    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } rgb_word_t;

    logic clk;
    logic rst_n;

    hsvc_hsv_if hsv_ch ();
    hsvc_rgb_if rgb_ch ();

    hsv_to_rgb_converter_core i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .hsv   (hsv_ch),
        .rgb   (rgb_ch)
    );

    // pixels waiting to be sent and rgb words waiting to come out
    hsv_word_t pending_pixels[$];
    rgb_word_t expected_rgb[$];

    int  error_count;
    int  pixels_sent;
    int  words_checked;
    int  clamped_pixels;
    int  sector_hits[6];
    int  cycle_count;
    bit  offer_taken;
    int  burst_left;
    int  gap_left;
    int  stall_mode;
    int  stall_left;
    int  mode_left;

    // exact integer hsv to rgb conversion
    function automatic rgb_word_t convert_pixel(hsv_word_t px);
        longint unsigned h, s, v, hm, hue_dist, cn, xn, mn, rn, gn, bn, den;
        sector_t         sec;
        rgb_word_t       res;
        h = px.hue;
        s = px.saturation;
        v = px.brightness;
        if (h >= HUE_FULL)
            h = 0;
        if (s > SV_ONE)
            s = SV_ONE;
        if (v > SV_ONE)
            v = SV_ONE;
        hm       = h % (2 * DEG_UNITS);
        hue_dist = (hm >= DEG_UNITS) ? (hm - DEG_UNITS) : (DEG_UNITS - hm);
        cn       = v * s * DEG_UNITS;
        xn       = v * s * (DEG_UNITS - hue_dist);
        mn       = ((v << SV_FRAC_BITS_DEF) * DEG_UNITS) - cn;
        sec      = sector_t'(3'(h / DEG_UNITS));
        unique case (sec)
            SEC_0:   begin rn = cn; gn = xn; bn = 0;  end
            SEC_1:   begin rn = xn; gn = cn; bn = 0;  end
            SEC_2:   begin rn = 0;  gn = cn; bn = xn; end
            SEC_3:   begin rn = 0;  gn = xn; bn = cn; end
            SEC_4:   begin rn = xn; gn = 0;  bn = cn; end
            default: begin rn = cn; gn = 0;  bn = xn; end
        endcase
        den = (longint'(1) << (2 * SV_FRAC_BITS_DEF)) * DEG_UNITS;
        res.red   = 8'((255 * (rn + mn)) / den);
        res.green = 8'((255 * (gn + mn)) / den);
        res.blue  = 8'((255 * (bn + mn)) / den);
        return res;
    endfunction

    task automatic add_pixel(int unsigned h, int unsigned s, int unsigned v);
        hsv_word_t px;
        px.hue        = 15'(h);
        px.saturation = 9'(s);
        px.brightness = 9'(v);
        pending_pixels.push_back(px);
    endtask

    // random hue: mostly in range, some on sector edges, some above 360 degrees
    function automatic int unsigned pick_hue();
        int unsigned roll;
        int unsigned edge_hue;
        roll = $urandom_range(0, 99);
        if (roll < 78)
            return $urandom_range(0, HUE_FULL);
        if (roll < 90)
        begin
            edge_hue = $urandom_range(0, 6) * DEG_UNITS;
            if (edge_hue > 0 && $urandom_range(0, 1))
                edge_hue = edge_hue - 1;
            return edge_hue;
        end
        return $urandom_range(HUE_FULL + 1, 32767);
    endfunction

    // random saturation / value: mostly in range, some at the ends, some clamped
    function automatic int unsigned pick_fraction();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 78)
            return $urandom_range(0, SV_ONE);
        if (roll < 90)
            return $urandom_range(0, 1) ? SV_ONE : 0;
        return $urandom_range(SV_ONE + 1, 511);
    endfunction

    // clock
    initial
    begin
        clk = 1'b0;
    end

    always #HALF_PERIOD clk = ~clk;

    // cycle limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d words outstanding", $time, expected_rgb.size());
            $display("tb_hsv_to_rgb_converter_core: errors");
            $finish;
        end
    end

    // input side: record accepted pixels and their expected rgb word
    always @(posedge clk)
    begin
        hsv_word_t px;
        if (rst_n && hsv_ch.valid && hsv_ch.ready)
        begin
            px.hue        = hsv_ch.hue;
            px.saturation = hsv_ch.saturation;
            px.brightness = hsv_ch.brightness;
            expected_rgb.push_back(convert_pixel(px));
            pixels_sent <= pixels_sent + 1;
            if (px.hue > HUE_FULL || px.saturation > SV_ONE || px.brightness > SV_ONE)
                clamped_pixels <= clamped_pixels + 1;
            if (px.hue < HUE_FULL)
                sector_hits[px.hue / DEG_UNITS] <= sector_hits[px.hue / DEG_UNITS] + 1;
            else
                sector_hits[0] <= sector_hits[0] + 1;
            offer_taken <= 1'b1;
        end
        else
        begin
            offer_taken <= 1'b0;
        end
    end

    // driver: bursts of pixels separated by random gaps
    always @(negedge clk)
    begin
        hsv_word_t px;
        if (rst_n && (!hsv_ch.valid || offer_taken))
        begin
            if (gap_left > 0)
            begin
                gap_left = gap_left - 1;
                hsv_ch.valid <= 1'b0;
            end
            else if (pending_pixels.size() > 0)
            begin
                px = pending_pixels.pop_front();
                hsv_ch.valid      <= 1'b1;
                hsv_ch.hue        <= px.hue;
                hsv_ch.saturation <= px.saturation;
                hsv_ch.brightness <= px.brightness;
                burst_left = burst_left - 1;
                if (burst_left <= 0)
                begin
                    burst_left = ($urandom_range(0, 7) == 0) ? 120 : $urandom_range(1, 30);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
            else
            begin
                hsv_ch.valid <= 1'b0;
            end
        end
    end

    // sink: stall pattern switches between free flow, random, sparse and long holds
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (mode_left <= 0)
            begin
                stall_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(20, 120);
            end
            mode_left = mode_left - 1;
            unique case (stall_mode)
                0: rgb_ch.ready <= 1'b1;
                1: rgb_ch.ready <= 1'($urandom_range(0, 1));
                2: rgb_ch.ready <= (cycle_count % 4 == 0);
                default:
                begin
                    if (stall_left > 0)
                    begin
                        stall_left = stall_left - 1;
                        rgb_ch.ready <= 1'b0;
                    end
                    else
                    begin
                        stall_left = $urandom_range(0, 12);
                        rgb_ch.ready <= 1'b1;
                    end
                end
            endcase
        end
    end

    // output checker
    always @(posedge clk)
    begin
        rgb_word_t want;
        if (rst_n && rgb_ch.valid && rgb_ch.ready)
        begin
            if (expected_rgb.size() == 0)
            begin
                $display("%0t: unexpected rgb word r=%0d g=%0d b=%0d", $time,
                         rgb_ch.red, rgb_ch.green, rgb_ch.blue);
                error_count <= error_count + 1;
            end
            else
            begin
                want = expected_rgb.pop_front();
                words_checked <= words_checked + 1;
                if (rgb_ch.red !== want.red || rgb_ch.green !== want.green ||
                    rgb_ch.blue !== want.blue)
                begin
                    $display("%0t: rgb mismatch expected r=%0d g=%0d b=%0d actual r=%0d g=%0d b=%0d",
                             $time, want.red, want.green, want.blue,
                             rgb_ch.red, rgb_ch.green, rgb_ch.blue);
                    error_count <= error_count + 1;
                end
            end
        end
    end

    // stimulus and end of run
    initial
    begin
        int unsigned s;
        int unsigned v;
        error_count    = 0;
        pixels_sent    = 0;
        words_checked  = 0;
        clamped_pixels = 0;
        cycle_count    = 0;
        offer_taken    = 1'b0;
        burst_left     = 0;
        gap_left       = 0;
        stall_mode     = 0;
        stall_left     = 0;
        mode_left      = 0;
        foreach (sector_hits[i])
            sector_hits[i] = 0;
        rst_n              = 1'b0;
        hsv_ch.valid       = 1'b0;
        hsv_ch.hue         = '0;
        hsv_ch.saturation  = '0;
        hsv_ch.brightness  = '0;
        rgb_ch.ready       = 1'b0;

        // directed: sector edges, extremes of every field, clamping
        add_pixel(0, 256, 256);
        add_pixel(DEG_UNITS - 1, 256, 256);
        add_pixel(DEG_UNITS, 256, 256);
        add_pixel(2 * DEG_UNITS - 1, 256, 256);
        add_pixel(2 * DEG_UNITS, 256, 256);
        add_pixel(3 * DEG_UNITS, 256, 256);
        add_pixel(4 * DEG_UNITS, 256, 256);
        add_pixel(5 * DEG_UNITS - 1, 256, 256);
        add_pixel(5 * DEG_UNITS, 256, 256);
        add_pixel(HUE_FULL - 1, 256, 256);
        add_pixel(HUE_FULL, 256, 256);
        add_pixel(HUE_FULL + 1, 256, 256);
        add_pixel(32767, 256, 256);
        add_pixel(1800, 0, 256);
        add_pixel(1800, 256, 0);
        add_pixel(1800, 0, 0);
        add_pixel(9000, 511, 511);
        add_pixel(9000, 257, 128);
        add_pixel(9000, 128, 257);
        add_pixel(16384, 255, 255);
        add_pixel(21000, 1, 1);
        add_pixel(13000, 170, 200);
        add_pixel(5 * DEG_UNITS + 1920, 511, 255);
        add_pixel(7680 + 3839, 85, 511);

        // random pixels
        repeat (RANDOM_PIXELS)
        begin
            s = pick_fraction();
            v = pick_fraction();
            add_pixel(pick_hue(), s, v);
        end

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // drain input, then output, then watch for strays
        while (pending_pixels.size() > 0 || hsv_ch.valid)
            @(posedge clk);
        while (expected_rgb.size() > 0)
            @(posedge clk);
        repeat (3 * PIPE_LATENCY) @(posedge clk);

        $display("pixels sent %0d, rgb words checked %0d, clamped inputs %0d",
                 pixels_sent, words_checked, clamped_pixels);
        $display("sector hits %0d %0d %0d %0d %0d %0d", sector_hits[0], sector_hits[1],
                 sector_hits[2], sector_hits[3], sector_hits[4], sector_hits[5]);
        if (error_count == 0)
            $display("tb_hsv_to_rgb_converter_core: clean");
        else
            $display("tb_hsv_to_rgb_converter_core: errors");
        $finish;
    end

endmodule

// File: files.f
rtl/core/hsvc_pkg.sv
rtl/core/hsvc_hsv_if.sv
rtl/core/hsvc_rgb_if.sv
rtl/core/hsvc_sector.sv
rtl/core/hsvc_scale.sv
rtl/core/hsvc_div15.sv
rtl/core/hsv_to_rgb_converter_core.sv
test/tb_hsv_to_rgb_converter_core.sv
